[sv/proximity_swipe_gesture_detector_macros.svh]
// ----------------------------------------------------------------------------
// Proximity swipe gesture detector - assertion macros
// Shared concurrent assertion helpers; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_SWIPE_GESTURE_DETECTOR_MACROS_SVH
`define PROXIMITY_SWIPE_GESTURE_DETECTOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define PSGD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication
`define PSGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define PSGD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PSGD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/psgd_pkg.sv]
// ----------------------------------------------------------------------------
// Proximity swipe gesture detector - package
// Shared types, constants and gesture codes.
// ----------------------------------------------------------------------------
package psgd_pkg;

  localparam int NUM_CH = 3;

  typedef logic [31:0] stamp_t;
  typedef logic [15:0] level_t;

  // Times above this count as close to wrapping
  localparam stamp_t NEAR_WRAP_LIMIT = 32'hFC00_0000;
  localparam stamp_t WRAP_SHIFT      = 32'h1FFF_FFFF;
  // Dwell that at least one channel must exceed for a swipe to count
  localparam stamp_t MIN_DWELL       = 32'd10;

  typedef enum logic [2:0] {
    GESTURE_NONE  = 3'd0,
    GESTURE_UP    = 3'd1,
    GESTURE_DOWN  = 3'd2,
    GESTURE_LEFT  = 3'd3,
    GESTURE_RIGHT = 3'd4
  } swipe_code_t;

  // Stamps captured for one transaction once its sample has been applied
  typedef struct packed {
    logic                     eval;
    stamp_t [NUM_CH-1:0]      entry_stamp;
    stamp_t [NUM_CH-1:0]      exit_stamp;
  } snap_t;

  // Dwell stage result
  typedef struct packed {
    logic                     go;
    logic                     near_wrap;
    stamp_t [NUM_CH-1:0]      entry_stamp;
    stamp_t [NUM_CH-1:0]      half_dwell;
  } dwell_t;

  // Midpoints ready for classification
  typedef struct packed {
    logic                     go;
    stamp_t [NUM_CH-1:0]      mid;
  } mid_t;

endpackage

[sv/proximity_swipe_gesture_detector.sv]
// ----------------------------------------------------------------------------
// Proximity swipe gesture detector - top level
// Tracks three proximity channels and reports up/down/left/right swipes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall carries one sample (sample_time and three
//   channel levels). A transaction completes when in_valid is high and
//   in_stall is low. Every input transaction yields exactly one result.
//   Output channel: out_valid/out_stall carries gesture_code (0 none, 1 up,
//   2 down, 3 left, 4 right); a transaction completes when out_valid is high
//   and out_stall is low.
//   Configuration: cfg_we writes cfg_wdata into the proximity threshold.
//   The result passes the input, snap, dwell, midpoint and result registers.
//   Throughput: one sample per cycle while in_stall is low; the entry/exit stamp
//   registers in the tracking stage are updated in the same cycle the sample is applied.
//   Reset (rst, synchronous): threshold 0, all stamps and presence flags
//   cleared, pipeline empty. No clearing pass is needed.
//   Stall: each of the five register stages holds only while its successor
//   holds, so bubbles are squeezed out and in_stall rises only once the
//   whole pipeline is full behind a stalled result.
// ----------------------------------------------------------------------------
module proximity_swipe_gesture_detector (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  psgd_pkg::level_t cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  psgd_pkg::stamp_t sample_time,
  input  psgd_pkg::level_t level_channel_a,
  input  psgd_pkg::level_t level_channel_b,
  input  psgd_pkg::level_t level_channel_c,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       gesture_code
);

  logic                  snap_valid;
  psgd_pkg::snap_t       snap;
  logic                  snap_stall;
  logic                  mid_valid;
  psgd_pkg::mid_t        mid;
  logic                  mid_stall;
  psgd_pkg::swipe_code_t gesture;

  // Channel tracking
  psgd_track u_track (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample_time     (sample_time),
    .level_channel_a (level_channel_a),
    .level_channel_b (level_channel_b),
    .level_channel_c (level_channel_c),
    .snap_valid      (snap_valid),
    .snap            (snap),
    .snap_stall      (snap_stall)
  );

  // Dwell and midpoints
  psgd_mid u_mid (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_stall (snap_stall),
    .mid_valid  (mid_valid),
    .mid        (mid),
    .mid_stall  (mid_stall)
  );

  // Classification and result register
  psgd_class u_class (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid       (mid),
    .mid_stall (mid_stall),
    .out_valid (out_valid),
    .gesture   (gesture),
    .out_stall (out_stall)
  );

  assign gesture_code = 3'(gesture);

endmodule

[sv/psgd_track.sv]
// ----------------------------------------------------------------------------
// Proximity swipe gesture detector - channel tracking
// Input register, threshold register and per-channel entry/exit stamps.
// ----------------------------------------------------------------------------
`include "proximity_swipe_gesture_detector_macros.svh"

module psgd_track (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  psgd_pkg::level_t cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  psgd_pkg::stamp_t sample_time,
  input  psgd_pkg::level_t level_channel_a,
  input  psgd_pkg::level_t level_channel_b,
  input  psgd_pkg::level_t level_channel_c,
  output logic             snap_valid,
  output psgd_pkg::snap_t  snap,
  input  logic             snap_stall
);

  localparam int NCH = psgd_pkg::NUM_CH;

  logic                               s0_valid;
  psgd_pkg::stamp_t                   s0_time;
  psgd_pkg::level_t [NCH-1:0]         s0_level;
  psgd_pkg::level_t                   threshold;
  logic [NCH-1:0]                     present;
  psgd_pkg::stamp_t [NCH-1:0]         entry_stamp;
  psgd_pkg::stamp_t [NCH-1:0]         exit_stamp;

  logic                               s0_hold;
  logic                               s1_hold;
  logic                               s0_move;
  logic [NCH-1:0]                     above;
  psgd_pkg::stamp_t [NCH-1:0]         entry_next;
  psgd_pkg::stamp_t [NCH-1:0]         exit_next;
  logic                               all_below;
  logic                               all_recorded;

  // Pipeline holds
  assign s1_hold  = snap_valid && snap_stall;
  assign s0_hold  = s0_valid && s1_hold;
  assign s0_move  = s0_valid && !s1_hold;
  assign in_stall = s0_hold;

  // Apply the sample to each channel's presence and stamps
  always_comb begin
    all_recorded = 1'b1;
    for (int k = 0; k < NCH; k++) begin
      above[k]      = s0_level[k] >= threshold;
      entry_next[k] = (above[k] && !present[k]) ? s0_time : entry_stamp[k];
      exit_next[k]  = (!above[k] && present[k]) ? s0_time : exit_stamp[k];
      if (entry_next[k] == '0 || exit_next[k] == '0) begin
        all_recorded = 1'b0;
      end
    end
    all_below = ~|above;
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid    <= 1'b0;
      snap_valid  <= 1'b0;
      threshold   <= '0;
      present     <= '0;
      entry_stamp <= '0;
      exit_stamp  <= '0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (!s0_hold) begin
        s0_valid <= in_valid;
      end
      if (!s1_hold) begin
        snap_valid <= s0_valid;
      end
      if (s0_move) begin
        present <= above;
        if (all_below) begin
          entry_stamp <= '0;
          exit_stamp  <= '0;
        end else begin
          entry_stamp <= entry_next;
          exit_stamp  <= exit_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !s0_hold) begin
      s0_time     <= sample_time;
      s0_level[0] <= level_channel_a;
      s0_level[1] <= level_channel_b;
      s0_level[2] <= level_channel_c;
    end
    if (s0_move) begin
      snap.eval        <= all_below && all_recorded;
      snap.entry_stamp <= entry_next;
      snap.exit_stamp  <= exit_next;
    end
  end

  // Stamps and presence are clear after an all-below transaction
  `PSGD_ASSERT_NEXT(a_clear_after_below, clk, rst, s0_move && all_below, entry_stamp == '0 && exit_stamp == '0 && present == '0)
  // Evaluation only ever sees six recorded times
  `PSGD_ASSERT_IMPLIES(a_eval_recorded, clk, rst, snap_valid && snap.eval, snap.entry_stamp[0] != '0 && snap.entry_stamp[1] != '0 && snap.entry_stamp[2] != '0 && snap.exit_stamp[0] != '0 && snap.exit_stamp[1] != '0 && snap.exit_stamp[2] != '0)
  // Stamps change only when a transaction is applied
  `PSGD_ASSERT_NEXT(a_state_hold, clk, rst, !s0_move, $stable(entry_stamp) && $stable(exit_stamp) && $stable(present))

endmodule

[sv/psgd_mid.sv]
// ----------------------------------------------------------------------------
// Proximity swipe gesture detector - midpoint stages
// Wrap detection, dwell times and entry/exit midpoints, two register stages.
// ----------------------------------------------------------------------------
module psgd_mid (
  input  logic             clk,
  input  logic             rst,
  input  logic             snap_valid,
  input  psgd_pkg::snap_t  snap,
  output logic             snap_stall,
  output logic             mid_valid,
  output psgd_pkg::mid_t   mid,
  input  logic             mid_stall
);

  localparam int NCH = psgd_pkg::NUM_CH;

  logic                        d_valid;
  psgd_pkg::dwell_t            d;
  logic                        s2_hold;
  logic                        s3_hold;
  psgd_pkg::stamp_t [NCH-1:0]  dwell;
  logic                        near_wrap;
  logic                        any_long;
  psgd_pkg::stamp_t            shift;
  psgd_pkg::stamp_t [NCH-1:0]  mid_next;

  assign s3_hold    = mid_valid && mid_stall;
  assign s2_hold    = d_valid && s3_hold;
  assign snap_stall = s2_hold;

  // Dwell per channel; a common shift leaves it unchanged
  always_comb begin
    near_wrap = 1'b0;
    any_long  = 1'b0;
    for (int k = 0; k < NCH; k++) begin
      dwell[k] = snap.exit_stamp[k] - snap.entry_stamp[k];
      if (snap.entry_stamp[k] > psgd_pkg::NEAR_WRAP_LIMIT ||
          snap.exit_stamp[k] > psgd_pkg::NEAR_WRAP_LIMIT) begin
        near_wrap = 1'b1;
      end
      if (dwell[k] > psgd_pkg::MIN_DWELL) begin
        any_long = 1'b1;
      end
    end
  end

  // Midpoint = entry + wrap shift + half dwell
  always_comb begin
    shift = d.near_wrap ? psgd_pkg::WRAP_SHIFT : '0;
    for (int k = 0; k < NCH; k++) begin
      mid_next[k] = d.entry_stamp[k] + shift + d.half_dwell[k];
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      mid_valid <= 1'b0;
    end else begin
      if (!s2_hold) begin
        d_valid <= snap_valid;
      end
      if (!s3_hold) begin
        mid_valid <= d_valid;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (snap_valid && !s2_hold) begin
      d.go          <= snap.eval && any_long;
      d.near_wrap   <= near_wrap;
      d.entry_stamp <= snap.entry_stamp;
      for (int k = 0; k < NCH; k++) begin
        d.half_dwell[k] <= {1'b0, dwell[k][31:1]};
      end
    end
    if (d_valid && !s3_hold) begin
      mid.go  <= d.go;
      mid.mid <= mid_next;
    end
  end

endmodule

[sv/psgd_class.sv]
// ----------------------------------------------------------------------------
// Proximity swipe gesture detector - classifier
// Midpoint gaps, direction rules and the result register.
// ----------------------------------------------------------------------------
module psgd_class (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  mid_valid,
  input  psgd_pkg::mid_t        mid,
  output logic                  mid_stall,
  output logic                  out_valid,
  output psgd_pkg::swipe_code_t gesture,
  input  logic                  out_stall
);

  logic                  out_hold;
  psgd_pkg::stamp_t      m0;
  psgd_pkg::stamp_t      m1;
  psgd_pkg::stamp_t      m2;
  psgd_pkg::stamp_t      dx;
  psgd_pkg::stamp_t      dy1;
  psgd_pkg::stamp_t      dy2;
  psgd_pkg::swipe_code_t gesture_next;

  function automatic psgd_pkg::stamp_t abs_gap(input psgd_pkg::stamp_t a,
                                               input psgd_pkg::stamp_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign out_hold  = out_valid && out_stall;
  assign mid_stall = out_hold;

  assign m0  = mid.mid[0];
  assign m1  = mid.mid[1];
  assign m2  = mid.mid[2];
  assign dx  = abs_gap(m1, m2);
  assign dy1 = abs_gap(m0, m1);
  assign dy2 = abs_gap(m0, m2);

  // Direction rules, first match wins
  always_comb begin
    priority if (!mid.go) begin
      gesture_next = psgd_pkg::GESTURE_NONE;
    end else if ((m1 < m0 && dy1 > dx) || (m1 < m2 && dy1 > dy2)) begin
      gesture_next = psgd_pkg::GESTURE_UP;
    end else if ((m0 < m1 && dy1 > dx) || (m2 < m1 && dy1 > dy2)) begin
      gesture_next = psgd_pkg::GESTURE_DOWN;
    end else if ((m2 < m0 && dy2 > dy1) || (m2 < m1 && dx > dy1)) begin
      gesture_next = psgd_pkg::GESTURE_LEFT;
    end else if ((m0 < m2 && dy2 > dy1) || (m1 < m2 && dx > dy1)) begin
      gesture_next = psgd_pkg::GESTURE_RIGHT;
    end else begin
      gesture_next = psgd_pkg::GESTURE_NONE;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_hold) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid && !out_hold) begin
      gesture <= gesture_next;
    end
  end

endmodule

[tb/gesture_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gesture checker
// Watches the sample and gesture channels of the swipe detector. It tracks
// entry and exit stamps per channel and works out each expected gesture,
// then compares every gesture transaction against the oldest one waiting.
// ----------------------------------------------------------------------------
module gesture_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  psgd_pkg::level_t cfg_wdata,
  input  logic             in_valid,
  input  logic             in_stall,
  input  psgd_pkg::stamp_t sample_time,
  input  psgd_pkg::level_t level_channel_a,
  input  psgd_pkg::level_t level_channel_b,
  input  psgd_pkg::level_t level_channel_c,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [2:0]       gesture_code,
  output int               mismatches,
  output int               awaited
);

  // Shadow of the detector state
  psgd_pkg::level_t      threshold;
  psgd_pkg::stamp_t      entry_at [3];
  psgd_pkg::stamp_t      exit_at [3];
  logic                  present [3];
  psgd_pkg::swipe_code_t pending_gestures [$];
  psgd_pkg::swipe_code_t want;

  // Direction of a completed swipe; rebases the stamps when close to wrapping
  function automatic psgd_pkg::swipe_code_t swipe_direction();
    psgd_pkg::stamp_t mid [3];
    psgd_pkg::stamp_t dwell;
    psgd_pkg::stamp_t dx;
    psgd_pkg::stamp_t dy1;
    psgd_pkg::stamp_t dy2;
    logic             wrap_near;
    logic             long_dwell;
    int               k;
    wrap_near  = 1'b0;
    long_dwell = 1'b0;
    for (k = 0; k < 3; k++) begin
      if (entry_at[k] > psgd_pkg::NEAR_WRAP_LIMIT || exit_at[k] > psgd_pkg::NEAR_WRAP_LIMIT)
        wrap_near = 1'b1;
    end
    for (k = 0; k < 3; k++) begin
      if (wrap_near) begin
        entry_at[k] = entry_at[k] + psgd_pkg::WRAP_SHIFT;
        exit_at[k]  = exit_at[k] + psgd_pkg::WRAP_SHIFT;
      end
      dwell  = exit_at[k] - entry_at[k];
      mid[k] = entry_at[k] + (dwell >> 1);
      if (dwell > psgd_pkg::MIN_DWELL)
        long_dwell = 1'b1;
    end
    if (!long_dwell)
      return psgd_pkg::GESTURE_NONE;
    dx  = (mid[1] > mid[2]) ? mid[1] - mid[2] : mid[2] - mid[1];
    dy1 = (mid[0] > mid[1]) ? mid[0] - mid[1] : mid[1] - mid[0];
    dy2 = (mid[0] > mid[2]) ? mid[0] - mid[2] : mid[2] - mid[0];
    // Priority order: up, down, left, right
    if ((mid[1] < mid[0] && dy1 > dx) || (mid[1] < mid[2] && dy1 > dy2))
      return psgd_pkg::GESTURE_UP;
    if ((mid[0] < mid[1] && dy1 > dx) || (mid[2] < mid[1] && dy1 > dy2))
      return psgd_pkg::GESTURE_DOWN;
    if ((mid[2] < mid[0] && dy2 > dy1) || (mid[2] < mid[1] && dx > dy1))
      return psgd_pkg::GESTURE_LEFT;
    if ((mid[0] < mid[2] && dy2 > dy1) || (mid[1] < mid[2] && dx > dy1))
      return psgd_pkg::GESTURE_RIGHT;
    return psgd_pkg::GESTURE_NONE;
  endfunction

  // Applies one sample to the shadow state and returns its gesture
  function automatic psgd_pkg::swipe_code_t track_sample(
    input psgd_pkg::stamp_t now,
    input psgd_pkg::level_t la,
    input psgd_pkg::level_t lb,
    input psgd_pkg::level_t lc
  );
    psgd_pkg::level_t      lvl [3];
    psgd_pkg::swipe_code_t result;
    logic                  quiet;
    logic                  complete;
    int                    k;
    lvl[0]   = la;
    lvl[1]   = lb;
    lvl[2]   = lc;
    quiet    = 1'b1;
    complete = 1'b1;
    result   = psgd_pkg::GESTURE_NONE;
    for (k = 0; k < 3; k++) begin
      if (lvl[k] >= threshold) begin
        quiet = 1'b0;
        if (!present[k]) begin
          present[k]  = 1'b1;
          entry_at[k] = now;
        end
      end else if (present[k]) begin
        present[k] = 1'b0;
        exit_at[k] = now;
      end
    end
    // All channels clear: evaluate if every stamp was recorded, then clear
    if (quiet) begin
      for (k = 0; k < 3; k++) begin
        if (entry_at[k] == '0 || exit_at[k] == '0)
          complete = 1'b0;
      end
      if (complete)
        result = swipe_direction();
      for (k = 0; k < 3; k++) begin
        entry_at[k] = '0;
        exit_at[k]  = '0;
      end
    end
    return result;
  endfunction

  // Prediction and comparison at every rising edge
  always @(posedge clk) begin
    if (rst) begin
      threshold  = '0;
      for (int k = 0; k < 3; k++) begin
        entry_at[k] = '0;
        exit_at[k]  = '0;
        present[k]  = 1'b0;
      end
      pending_gestures.delete();
      mismatches = 0;
    end else begin
      if (in_valid && !in_stall)
        pending_gestures.push_back(track_sample(sample_time, level_channel_a,
                                                level_channel_b, level_channel_c));
      if (out_valid && !out_stall) begin
        if (pending_gestures.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: gesture transaction %0d with none expected", $time, gesture_code);
          mismatches++;
        end else begin
          want = pending_gestures.pop_front();
          if (gesture_code !== want) begin
            if (mismatches < 10)
              $display("%0t: gesture_code expected %0d, got %0d", $time, want, gesture_code);
            mismatches++;
          end
        end
      end
      if (cfg_we)
        threshold = cfg_wdata;
    end
    awaited = pending_gestures.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Swipe detector testbench
// Drives directed swipes in each direction, then random swipe sequences and
// noise under several thresholds, with random gaps and back-pressure. The
// checker module predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  psgd_pkg::level_t cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  psgd_pkg::stamp_t sample_time;
  psgd_pkg::level_t level_channel_a;
  psgd_pkg::level_t level_channel_b;
  psgd_pkg::level_t level_channel_c;
  logic             out_valid;
  logic             out_stall;
  logic [2:0]       gesture_code;

  int               mismatches;
  int               awaited;
  int               items_sent;
  psgd_pkg::level_t threshold_now;
  logic             steady;       // no sender gaps for the current sequence
  int               stall_left;
  logic             stall_phase;
  int               stall_pick;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  proximity_swipe_gesture_detector uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample_time     (sample_time),
    .level_channel_a (level_channel_a),
    .level_channel_b (level_channel_b),
    .level_channel_c (level_channel_c),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .gesture_code    (gesture_code)
  );

  gesture_checker gesture_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample_time     (sample_time),
    .level_channel_a (level_channel_a),
    .level_channel_b (level_channel_b),
    .level_channel_c (level_channel_c),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .gesture_code    (gesture_code),
    .mismatches      (mismatches),
    .awaited         (awaited)
  );

  // Watchdog
  initial begin
    #8_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Receiver back-pressure: runs of stall and no stall, mostly short
  always @(negedge clk) begin
    if (rst) begin
      stall_left  = 0;
      stall_phase = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 45) begin
        stall_phase = 1'b0;
        stall_left  = $urandom_range(1, 12);
      end else if (stall_pick < 55) begin
        stall_phase = 1'b0;
        stall_left  = $urandom_range(30, 80);
      end else if (stall_pick < 92) begin
        stall_phase = 1'b1;
        stall_left  = $urandom_range(0, 3);
      end else begin
        stall_phase = 1'b1;
        stall_left  = $urandom_range(10, 40);
      end
    end
    out_stall <= stall_phase;
  end

  // Random level at or above the threshold, often right on it
  function automatic psgd_pkg::level_t level_above();
    if ($urandom_range(0, 4) == 0)
      return threshold_now;
    return psgd_pkg::level_t'($urandom_range(65535, threshold_now));
  endfunction

  // Random level below the threshold, often just below it
  function automatic psgd_pkg::level_t level_below();
    if ($urandom_range(0, 4) == 0)
      return threshold_now - 1'b1;
    return psgd_pkg::level_t'($urandom_range(threshold_now - 1, 0));
  endfunction

  // One sample transaction, with an optional gap in front
  task automatic drive_item(input psgd_pkg::stamp_t t, input psgd_pkg::level_t a,
                            input psgd_pkg::level_t b, input psgd_pkg::level_t c);
    int pick;
    int gap;
    gap = 0;
    if (!steady) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90)
        gap = $urandom_range(5, 30);
      else if (pick >= 55)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    sample_time     = t;
    level_channel_a = a;
    level_channel_b = b;
    level_channel_c = c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Waits for the pipeline to drain, then writes the threshold
  task automatic set_threshold(input psgd_pkg::level_t value);
    in_valid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_we        = 1'b1;
    cfg_wdata     = value;
    threshold_now = value;
    @(negedge clk);
    cfg_we = 1'b0;
    // Clear any presence left over from the previous threshold
    if (value != '0)
      drive_item($urandom, level_below(), level_below(), level_below());
  endtask

  // Swipe over n samples; channel k is present on samples [in_k, out_k)
  task automatic run_swipe(input psgd_pkg::stamp_t base, input psgd_pkg::stamp_t step,
                           input int n, input int in_a, input int out_a,
                           input int in_b, input int out_b, input int in_c, input int out_c);
    psgd_pkg::level_t a;
    psgd_pkg::level_t b;
    psgd_pkg::level_t c;
    int               i;
    for (i = 0; i < n; i++) begin
      a = (i >= in_a && i < out_a) ? level_above() : level_below();
      b = (i >= in_b && i < out_b) ? level_above() : level_below();
      c = (i >= in_c && i < out_c) ? level_above() : level_below();
      drive_item(base + psgd_pkg::stamp_t'(i) * step, a, b, c);
    end
  endtask

  // Well-formed swipe with random windows, base and spacing
  task automatic random_swipe();
    psgd_pkg::stamp_t base;
    psgd_pkg::stamp_t step;
    int               n;
    int               pick;
    int               win_in [3];
    int               win_out [3];
    int               k;
    n = $urandom_range(3, 9);
    for (k = 0; k < 3; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        win_in[k]  = 0;
        win_out[k] = 0;
      end else begin
        win_in[k]  = $urandom_range(0, n - 2);
        win_out[k] = $urandom_range(win_in[k] + 1, n - 1);
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 50)
      base = $urandom;
    else if (pick < 65)
      base = 32'hFC00_0000 - $urandom_range(0, 400);
    else if (pick < 80)
      base = 32'hFFFF_FFFF - $urandom_range(0, 300);
    else if (pick < 90)
      base = $urandom_range(0, 200);
    else
      base = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      step = $urandom_range(1, 12);
    else if (pick < 90)
      step = $urandom_range(13, 5000);
    else
      step = $urandom;
    steady = ($urandom_range(0, 3) == 0);
    run_swipe(base, step, n, win_in[0], win_out[0], win_in[1], win_out[1],
              win_in[2], win_out[2]);
    steady = 1'b0;
  endtask

  // Short burst of unstructured samples
  task automatic noise_burst();
    int count;
    count = $urandom_range(1, 6);
    repeat (count) begin
      if ($urandom_range(0, 1) == 0)
        drive_item($urandom, psgd_pkg::level_t'($urandom), psgd_pkg::level_t'($urandom),
                   psgd_pkg::level_t'($urandom));
      else
        drive_item($urandom,
                   $urandom_range(0, 1) ? level_above() : psgd_pkg::level_t'($urandom),
                   $urandom_range(0, 1) ? level_above() : psgd_pkg::level_t'($urandom),
                   $urandom_range(0, 1) ? level_below() : psgd_pkg::level_t'($urandom));
    end
  endtask

  // One random phase at a given threshold
  task automatic run_phase(input psgd_pkg::level_t value, input int count);
    int start;
    set_threshold(value);
    start = items_sent;
    while (items_sent - start < count) begin
      if (value != '0 && $urandom_range(0, 99) < 80)
        random_swipe();
      else
        noise_burst();
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    sample_time     = '0;
    level_channel_a = '0;
    level_channel_b = '0;
    level_channel_c = '0;
    steady          = 1'b0;
    items_sent      = 0;
    threshold_now   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset threshold of zero: everything counts as present
    drive_item('0, '0, '0, '0);
    drive_item(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // Directed swipes
    set_threshold(16'd100);
    run_swipe(32'hFFFF_FF00, 6, 5, 2, 4, 0, 2, 1, 3);   // up, near wrap
    run_swipe(32'd1000, 6, 5, 0, 2, 2, 4, 1, 3);        // down
    run_swipe(32'h0001_0000, 7, 5, 2, 4, 1, 3, 0, 2);   // left
    run_swipe(32'h1234_5678, 6, 5, 0, 2, 1, 3, 2, 4);   // right
    run_swipe(32'd5000, 2, 5, 0, 2, 1, 3, 2, 4);        // dwell too short
    run_swipe('0, 3, 2, 0, 1, 0, 0, 0, 0);              // entry at time zero, stamps missing

    // Random phases, extremes of the threshold among them
    run_phase(16'd1, 200);
    run_phase(16'hFFFF, 200);
    run_phase(psgd_pkg::level_t'($urandom_range(2, 16'hFFFE)), 200);
    run_phase(16'd0, 60);
    run_phase(16'h8000, 200);
    run_phase(psgd_pkg::level_t'($urandom_range(2, 16'hFFFE)), 200);
    run_phase(psgd_pkg::level_t'($urandom_range(2, 2000)), 200);

    // Drain
    in_valid = 1'b0;
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
